### src/clsr_pkg.sv
`default_nettype none

package clsr_pkg;

    localparam int RAW_W   = 31;
    localparam int DATA_W  = 32;
    localparam int PROD1_W = 47;

    localparam logic [30:0] MOD1         = 31'd2147483563;
    localparam logic [30:0] MOD2         = 31'd2147483399;
    localparam logic [30:0] MOD1_LESS    = 31'd2147483562;
    localparam logic [15:0] MUL1         = 16'd40014;
    localparam logic [15:0] MUL2         = 16'd40692;
    localparam logic [7:0]  FOLD1        = 8'd85;
    localparam logic [7:0]  FOLD2        = 8'd249;
    localparam logic [7:0]  FRAC_EST_MUL = 8'd170;
    localparam logic [31:0] FRACTION_MAX = 32'd4294966780;
    localparam logic [30:0] SECOND_RESET = 31'd123456789;
    localparam logic [30:0] SEED_RESET   = 31'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [RAW_W-1:0]         raw;
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;
    } item_t;

endpackage

`default_nettype wire

### src/clsr_front.sv
`default_nettype none

module clsr_front
    import clsr_pkg::*;
#(
    parameter int TABLE_SIZE = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wen,
    input  wire logic [RAW_W-1:0]         cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [DATA_W-1:0] s_lower,
    input  wire logic signed [DATA_W-1:0] s_upper,
    output logic                          q_valid,
    input  wire logic                     q_ready,
    output item_t                         q_item
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam logic [31:0] SLOT_DIV = 32'(1 + (32'(MOD1) - 1) / TABLE_SIZE);
    localparam logic [7:0] SLOT_RECIP = 8'((64'd1 << 31) / 64'(SLOT_DIV));
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(TABLE_SIZE - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_RED  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_DIV  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [RAW_W-1:0]         seed_reg;
    logic [RAW_W-1:0]         x1_reg;
    logic [RAW_W-1:0]         x2_reg;
    logic [PROD1_W-1:0]       p1_reg;
    logic [PROD1_W-1:0]       p2_reg;
    logic [RAW_W-1:0]         out_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [TABLE_SIZE-1:0]    valid_reg;
    logic [RAW_W-1:0]         rd_data_reg;
    logic                     rd_valid_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [DATA_W-1:0] hi_reg;
    logic [RAW_W-1:0]         rem_reg;
    logic [SLOT_W-1:0]        quot_reg;
    logic                     div_phase_reg;
    logic [RAW_W-1:0]         tab_mem [TABLE_SIZE];

    logic                     accept;
    logic [RAW_W-1:0]         seed_mod;
    logic [31:0]              sum1;
    logic [31:0]              sum2;
    logic [RAW_W-1:0]         x1_red;
    logic [RAW_W-1:0]         x2_red;
    logic [RAW_W-1:0]         tab_val;
    logic [31:0]              diff;
    logic [RAW_W-1:0]         y_val;
    logic [RAW_W+7:0]         est_prod;
    logic [SLOT_W-1:0]        quot_est;
    logic [31:0]              rem_left;
    logic                     div_ge;
    logic [SLOT_W-1:0]        quot_fin;
    logic                     div_last;

    assign s_ready = (state_reg == ST_IDLE) && q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        seed_mod = (seed_reg >= MOD1) ? (seed_reg - MOD1) : seed_reg;
        if (seed_mod == '0) begin
            seed_mod = RAW_W'(1);
        end

        sum1 = 32'(p1_reg[RAW_W-1:0]) + 32'(24'(p1_reg[PROD1_W-1:RAW_W]) * 24'(FOLD1));
        sum2 = 32'(p2_reg[RAW_W-1:0]) + 32'(24'(p2_reg[PROD1_W-1:RAW_W]) * 24'(FOLD2));
        x1_red = (sum1 >= {1'b0, MOD1}) ? RAW_W'(sum1 - {1'b0, MOD1}) : sum1[RAW_W-1:0];
        x2_red = (sum2 >= {1'b0, MOD2}) ? RAW_W'(sum2 - {1'b0, MOD2}) : sum2[RAW_W-1:0];

        tab_val = rd_valid_reg ? rd_data_reg : '0;
        diff    = {1'b0, tab_val} - {1'b0, x2_reg};
        if (diff[31] || (diff == '0)) begin
            diff = diff + {1'b0, MOD1_LESS};
        end
        y_val = diff[RAW_W-1:0];

        est_prod = (RAW_W+8)'(rem_reg) * (RAW_W+8)'(SLOT_RECIP);
        quot_est = est_prod[RAW_W +: SLOT_W];
        rem_left = {1'b0, rem_reg} - 32'(32'(quot_reg) * SLOT_DIV);
        div_ge   = rem_left >= SLOT_DIV;
        quot_fin = quot_reg + SLOT_W'(div_ge);
        if (quot_fin > SLOT_MAX) begin
            quot_fin = SLOT_MAX;
        end
        div_last = div_phase_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_RED;
            ST_RED:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign q_valid      = (state_reg == ST_UPD);
    assign q_item.raw   = y_val;
    assign q_item.lower = lo_reg;
    assign q_item.upper = hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seed_reg  <= SEED_RESET;
            x1_reg    <= '0;
            x2_reg    <= SECOND_RESET;
            out_reg   <= '0;
            slot_reg  <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                seed_reg <= cfg_wdata;
            end
            if (accept && (out_reg == '0)) begin
                x1_reg <= seed_mod;
            end
            if (state_reg == ST_RED) begin
                x1_reg <= x1_red;
                x2_reg <= x2_red;
            end
            if (state_reg == ST_UPD) begin
                out_reg             <= y_val;
                valid_reg[slot_reg] <= 1'b1;
            end
            if ((state_reg == ST_DIV) && div_last) begin
                slot_reg <= quot_fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lo_reg <= s_lower;
            hi_reg <= s_upper;
        end
        if (state_reg == ST_MUL) begin
            p1_reg       <= PROD1_W'(x1_reg) * PROD1_W'(MUL1);
            p2_reg       <= PROD1_W'(x2_reg) * PROD1_W'(MUL2);
            rd_valid_reg <= valid_reg[slot_reg];
        end
        if (state_reg == ST_UPD) begin
            rem_reg       <= y_val;
            div_phase_reg <= 1'b0;
        end
        if ((state_reg == ST_DIV) && !div_phase_reg) begin
            quot_reg      <= quot_est;
            div_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            rd_data_reg <= tab_mem[slot_reg];
        end
        if (state_reg == ST_UPD) begin
            tab_mem[slot_reg] <= x1_reg;
        end
    end

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> q_ready)
        else $error("Shuffle result pushed into a full queue.");

    a_output_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |=> (out_reg != '0))
        else $error("Shuffled output returned to zero after a draw.");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_MAX)
        else $error("Table slot beyond the table.");

endmodule

`default_nettype wire

### src/clsr_queue.sv
`default_nettype none

module clsr_queue
    import clsr_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire item_t  in_item,
    output logic        out_valid,
    input  wire logic   out_ready,
    output item_t       out_item
);

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    item_t                  mem_reg [QUEUE_DEPTH];
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Queue fill count beyond its depth.");

endmodule

`default_nettype wire

### src/clsr_back.sv
`default_nettype none

module clsr_back
    import clsr_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire item_t          q_item,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [RAW_W-1:0]    m_raw,
    output logic [DATA_W-1:0]   m_fraction,
    output logic [DATA_W-1:0]   m_scaled
);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [RAW_W-1:0]         raw1_reg, raw2_reg, raw3_reg, raw4_reg, raw5_reg;
    logic [DATA_W-1:0]        lo1_reg, lo2_reg, lo3_reg, lo4_reg;
    logic                     neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [DATA_W-1:0]        mag1_reg, mag2_reg, mag3_reg;
    logic [38:0]              t1_reg;
    logic [31:0]              r2_reg;
    logic [31:0]              qb2_reg;
    logic [DATA_W-1:0]        frac3_reg, frac4_reg, frac5_reg;
    logic [63:0]              prod4_reg;
    logic [DATA_W-1:0]        scaled5_reg;

    logic                     adv;
    logic signed [DATA_W:0]   width;
    logic [7:0]               d0;
    logic [31:0]              frac_q;
    logic [DATA_W-1:0]        off_mag;
    logic [DATA_W-1:0]        offset;

    assign adv     = !v5_reg || m_ready;
    assign q_ready = adv;

    always_comb begin
        width   = {q_item.upper[DATA_W-1], q_item.upper}
                - {q_item.lower[DATA_W-1], q_item.lower};
        d0      = t1_reg[38:31];
        frac_q  = qb2_reg + 32'(r2_reg >= {1'b0, MOD1});
        if (frac_q > FRACTION_MAX) begin
            frac_q = FRACTION_MAX;
        end
        off_mag = prod4_reg[63:32] + 32'(|prod4_reg[31:0]);
        offset  = neg4_reg ? (32'd0 - off_mag) : prod4_reg[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            raw1_reg <= q_item.raw;
            lo1_reg  <= q_item.lower;
            neg1_reg <= width[DATA_W];
            mag1_reg <= width[DATA_W] ? (q_item.lower - q_item.upper)
                                      : (q_item.upper - q_item.lower);
            t1_reg   <= 39'(q_item.raw) * 39'(FRAC_EST_MUL);

            raw2_reg <= raw1_reg;
            lo2_reg  <= lo1_reg;
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            r2_reg   <= 32'(t1_reg[30:0]) + 32'(15'(d0) * 15'(FOLD1));
            qb2_reg  <= {raw1_reg, 1'b0} + 32'(d0);

            raw3_reg  <= raw2_reg;
            lo3_reg   <= lo2_reg;
            neg3_reg  <= neg2_reg;
            mag3_reg  <= mag2_reg;
            frac3_reg <= frac_q;

            raw4_reg  <= raw3_reg;
            lo4_reg   <= lo3_reg;
            neg4_reg  <= neg3_reg;
            frac4_reg <= frac3_reg;
            prod4_reg <= 64'(frac3_reg) * 64'(mag3_reg);

            raw5_reg    <= raw4_reg;
            frac5_reg   <= frac4_reg;
            scaled5_reg <= lo4_reg + offset;
        end
    end

    assign m_valid    = v5_reg;
    assign m_raw      = raw5_reg;
    assign m_fraction = frac5_reg;
    assign m_scaled   = scaled5_reg;

    a_fraction_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (frac3_reg <= FRACTION_MAX))
        else $error("Fraction above its clamp.");

endmodule

`default_nettype wire

### src/combined_lcg_shuffle_random_top.sv
// Draws are made one at a time: for each request the draw sequencer accepts it, multiplies,
// reduces and updates the shuffle table, then picks the next table slot by a reciprocal
// multiplication followed by a single correction step.
// Between request acceptance and m_tvalid a result passes the sequencer states, the result
// queue and the fraction and scaling logic, which runs in a five-stage pipeline.
// Reset is synchronous and active low; the shuffle table reads as empty straight after reset.
`default_nettype none

module combined_lcg_shuffle_random_top
    import clsr_pkg::*;
#(
    parameter int TABLE_SIZE = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wen,
    input  wire logic [RAW_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // lower_bound [31:0], upper_bound [63:32]
    input  wire logic [63:0]       s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // raw_value [30:0], fraction [62:31], scaled_value [94:63], zero [95]
    output logic [95:0]            m_tdata
);

    logic              fq_valid;
    logic              fq_ready;
    item_t             fq_item;
    logic              qb_valid;
    logic              qb_ready;
    item_t             qb_item;
    logic [RAW_W-1:0]  m_raw;
    logic [DATA_W-1:0] m_fraction;
    logic [DATA_W-1:0] m_scaled;

    clsr_front #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_lower   (s_tdata[31:0]),
        .s_upper   (s_tdata[63:32]),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    clsr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    clsr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_item     (qb_item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_raw      (m_raw),
        .m_fraction (m_fraction),
        .m_scaled   (m_scaled)
    );

    assign m_tdata = {1'b0, m_scaled, m_fraction, m_raw};

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
    import clsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = 32;
    localparam int SETTLE_CYCLES = 24;

    localparam longint unsigned MOD_A      = 64'd2147483563;
    localparam longint unsigned MOD_B      = 64'd2147483399;
    localparam longint unsigned MUL_A      = 64'd40014;
    localparam longint unsigned MUL_B      = 64'd40692;
    localparam longint signed   MOD_A_LESS = 64'sd2147483562;
    localparam longint unsigned SLOT_DIV   = 64'd1 + (MOD_A - 64'd1) / TABLE_SIZE;
    localparam longint unsigned FRAC_CAP   = 64'd4294966780;
    localparam longint unsigned GEN_B_INIT = 64'd123456789;
    localparam logic [RAW_W-1:0] SEED_INIT = 31'd3;

    typedef struct {
        logic [RAW_W-1:0]  raw;
        logic [DATA_W-1:0] frac;
        logic [DATA_W-1:0] scaled;
    } draw_t;

    class draw_tracker;
        logic [RAW_W-1:0] seed_reg;
        longint unsigned  gen_a;
        longint unsigned  gen_b;
        longint unsigned  last_out;
        longint unsigned  slots [TABLE_SIZE];
        draw_t            pending_draws [$];
        int               errors;

        function void restart();
            seed_reg = SEED_INIT;
            gen_a    = 0;
            gen_b    = GEN_B_INIT;
            last_out = 0;
            foreach (slots[i]) slots[i] = 0;
            pending_draws.delete();
            errors = 0;
        endfunction

        function void write_seed(logic [RAW_W-1:0] value);
            seed_reg = value;
        endfunction

        function void note_request(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
            longint unsigned    slot;
            longint unsigned    frac;
            longint signed      diff;
            logic signed [33:0] span;
            logic signed [32:0] frac_s;
            logic signed [66:0] prod;
            draw_t              d;
            if (last_out == 0) begin
                gen_a = longint'(seed_reg) % MOD_A;
                if (gen_a == 0) gen_a = 1;
            end
            gen_a = (gen_a * MUL_A) % MOD_A;
            gen_b = (gen_b * MUL_B) % MOD_B;
            slot = last_out / SLOT_DIV;
            if (slot > TABLE_SIZE - 1) slot = TABLE_SIZE - 1;
            diff = $signed(slots[slot]) - $signed(gen_b);
            slots[slot] = gen_a;
            if (diff < 1) diff = diff + MOD_A_LESS;
            last_out = diff;
            frac = (last_out << 32) / MOD_A;
            if (frac > FRAC_CAP) frac = FRAC_CAP;
            span   = $signed({hi[31], hi}) - $signed({lo[31], lo});
            frac_s = $signed({1'b0, frac[31:0]});
            prod   = frac_s * span;
            d.raw    = last_out[RAW_W-1:0];
            d.frac   = frac[31:0];
            d.scaled = lo + prod[63:32];
            pending_draws.push_back(d);
        endfunction

        function void check_draw(logic [95:0] data);
            draw_t d;
            if (pending_draws.size() == 0) begin
                $display("%t: result with nothing outstanding, actual %h", $realtime, data);
                errors++;
                return;
            end
            d = pending_draws.pop_front();
            if (data[30:0] !== d.raw) begin
                $display("%t: raw_value expected %0d actual %0d", $realtime, d.raw, data[30:0]);
                errors++;
            end
            if (data[62:31] !== d.frac) begin
                $display("%t: fraction expected %0d actual %0d", $realtime, d.frac,
                         data[62:31]);
                errors++;
            end
            if (data[94:63] !== d.scaled) begin
                $display("%t: scaled_value expected %0d actual %0d", $realtime,
                         $signed(d.scaled), $signed(data[94:63]));
                errors++;
            end
            if (data[95] !== 1'b0) begin
                $display("%t: padding bit expected 0 actual %b", $realtime, data[95]);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_wen;
    logic [RAW_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [95:0]       m_tdata;

    draw_tracker tracker;
    bit          no_idle;
    bit          hold_request;

    combined_lcg_shuffle_random_top #(
        .TABLE_SIZE(TABLE_SIZE)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("combined_lcg_shuffle_random_top: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    task automatic send_draw(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        int gap;
        s_tdata  <= {hi, lo};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_request(lo, hi);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_seed(input logic [RAW_W-1:0] value);
        cfg_wdata <= value;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        tracker.write_seed(value);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_draws.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_draws(input int count);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        repeat (count) begin
            case ($urandom_range(0, 6))
                0, 1: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                2: begin
                    lo = $urandom;
                    hi = lo + $urandom_range(0, 1000);
                end
                3: begin
                    lo = $urandom;
                    hi = lo;
                end
                4: begin
                    hi = $urandom;
                    lo = hi + $urandom_range(0, 1000);
                end
                5: begin
                    lo = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    hi = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                default: begin
                    lo = 32'(int'($urandom_range(0, 200)) - 100);
                    hi = 32'(int'($urandom_range(0, 200)) - 100);
                end
            endcase
            send_draw(lo, hi);
        end
    endtask

    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) tracker.check_draw(m_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        logic [RAW_W-1:0] first_seed;
        int               seed_pick;
        tracker = new;
        tracker.restart();
        no_idle      = 1'b0;
        hold_request = 1'b0;
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Only the seed present at the first draw counts, so one is picked per run.
        seed_pick = $urandom_range(0, 6);
        case (seed_pick)
            0: first_seed = 31'd0;
            1: first_seed = 31'd2147483563;
            2: first_seed = 31'h7FFF_FFFF;
            3: first_seed = 31'd1;
            4: first_seed = 31'd2147483562;
            default: first_seed = RAW_W'($urandom);
        endcase
        if (seed_pick != 6) write_seed(first_seed);

        send_draw(32'h0000_0000, 32'h0000_0000);
        send_draw(32'h8000_0000, 32'h7FFF_FFFF);
        send_draw(32'h7FFF_FFFF, 32'h8000_0000);
        send_draw(32'h8000_0000, 32'h8000_0000);
        send_draw(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_draw(32'hFFFF_FFFF, 32'h0000_0000);
        send_draw(32'h0000_0000, 32'hFFFF_FFFF);
        send_draw(32'h0000_0000, 32'h0000_0001);
        send_draw(32'h0000_0001, 32'h0000_0000);
        send_draw(32'h8000_0000, 32'h0000_0000);
        send_draw(32'h0000_0000, 32'h7FFF_FFFF);
        send_draw(32'hFFFF_FF9C, 32'h0000_0064);
        send_draw(32'h0000_0064, 32'hFFFF_FF9C);
        send_draw(32'hAAAA_AAAA, 32'h5555_5555);
        send_draw(32'h5555_5555, 32'hAAAA_AAAA);
        send_draw(32'h0000_0007, 32'h0000_0007);
        drain();

        // A seed written after the first draw must leave the sequence alone.
        write_seed(31'h7FFF_FFFF);
        random_draws(200);
        drain();

        no_idle      = 1'b1;
        hold_request = 1'b1;
        random_draws(30);
        drain();

        write_seed(31'd0);
        random_draws(180);
        drain();

        no_idle = 1'b0;
        write_seed(RAW_W'($urandom));
        random_draws(200);
        drain();

        if (tracker.errors == 0 && tracker.pending_draws.size() == 0) begin
            $display("combined_lcg_shuffle_random_top: match");
        end else begin
            $display("combined_lcg_shuffle_random_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
src/clsr_pkg.sv
src/clsr_front.sv
src/clsr_queue.sv
src/clsr_back.sv
src/combined_lcg_shuffle_random_top.sv
tb/testbench.sv
